// ===== rtl/qtbd_pkg.sv =====
// Shared constants for the quadtree bitmap decoder.
`timescale 1ns / 1ps

package qtbd_pkg;

  // Port widths fixed by the interface.
  localparam int SYMBOL_W   = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int FILL_POS_W = 8;
  localparam int FILL_DIM_W = 9;

  // Symbol codes; code 3 is unused and ignored.
  localparam logic [SYMBOL_W-1:0] SYM_LEAF0 = 2'd0;
  localparam logic [SYMBOL_W-1:0] SYM_LEAF1 = 2'd1;
  localparam logic [SYMBOL_W-1:0] SYM_SPLIT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

  // Quadrant bit positions within a group mask (pop order TL first).
  localparam int QUAD_TL = 0;
  localparam int QUAD_TR = 1;
  localparam int QUAD_BL = 2;
  localparam int QUAD_BR = 3;
  localparam int QUAD_N  = 4;

endpackage

// ===== rtl/qtbd_stack_mem.sv =====
// Group stack memory: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps

module qtbd_stack_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A write to the address being read shows the new word next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/quadtree_bitmap_decoder_unit.sv =====
// Quadtree bitmap decoder top level: symbol stream in, rectangle fill words out.
`timescale 1ns / 1ps

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o   | symbol_i, start_image_i
//  out     | out       | out_valid_o / out_stall_i | fill_top/left/height/width, pixel, done
//
//  One symbol word per cycle while in_stall_o is low. A leaf word shows its fill word in the
//  cycle after acceptance. The rate is set by the top group register and the
//  prefetch of the stack memory's top entry, which is read again every cycle.
//  Reset (rst_ni low, async) empties the stack; rows and cols return to 1.
//  No clearing pass: memory entries are only read after being written.
//  in_stall_o rises only while a fill word waits and out_stall_i is high.
//  Config writes are always taken (cfg_ready_o is tied high).

module quadtree_bitmap_decoder_unit #(
  parameter int MAX_DIM     = 256,
  parameter int STACK_DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qtbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qtbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [qtbd_pkg::SYMBOL_W-1:0]    symbol_i,
  input  logic                             start_image_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [qtbd_pkg::FILL_POS_W-1:0]  fill_top_o,
  output logic [qtbd_pkg::FILL_POS_W-1:0]  fill_left_o,
  output logic [qtbd_pkg::FILL_DIM_W-1:0]  fill_height_o,
  output logic [qtbd_pkg::FILL_DIM_W-1:0]  fill_width_o,
  output logic                             pixel_value_o,
  output logic                             image_done_o
);

  import qtbd_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);      // coordinate bits
  localparam int DW    = $clog2(MAX_DIM + 1);  // size bits
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [DW-1:0]    MAX_C   = DW'(MAX_DIM);

  // A stack "group" is a parent rectangle plus the mask of its quadrants
  // still pending; the root image is a single group whose one entry is the
  // rectangle itself. The logical stack is the concatenation of groups.
  typedef struct packed {
    logic [CW-1:0]     top;
    logic [CW-1:0]     left;
    logic [DW-1:0]     height;
    logic [DW-1:0]     width;
    logic              single;
    logic [QUAD_N-1:0] mask;
  } group_t;

  localparam int GRP_W = $bits(group_t);

  // ---------------------------------------------------------------- registers
  logic [CFG_DATA_W-1:0] rows_q, cols_q;
  group_t                tg_q, tg_d;       // top group, held in flops
  logic [AW-1:0]         gc_q, gc_d;       // groups held in memory
  logic [CNT_W-1:0]      cnt_q, cnt_d;     // logical stack entries

  logic                  out_valid_q, out_valid_d;
  logic [CW-1:0]         o_top_q, o_left_q;
  logic [DW-1:0]         o_height_q, o_width_q;
  logic                  o_pixel_q, o_done_q;

  // ---------------------------------------------------------------- memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  group_t                mem_wdata;
  logic [GRP_W-1:0]      mem_rdata;
  group_t                mtop;

  logic acc, sym_leaf, sym_split;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign acc         = in_valid_i && !in_stall_o;
  assign sym_leaf    = (symbol_i == SYM_LEAF0) || (symbol_i == SYM_LEAF1);
  assign sym_split   = (symbol_i == SYM_SPLIT);
  assign mtop        = group_t'(mem_rdata);

  // ---------------------------------------------------------------- restart view
  logic [DW-1:0]    rows_c, cols_c;
  group_t           a_tg;
  logic [CNT_W-1:0] a_cnt;
  logic [AW-1:0]    a_gc;

  assign rows_c = (32'(rows_q) > 32'(MAX_DIM)) ? MAX_C : DW'(rows_q);
  assign cols_c = (32'(cols_q) > 32'(MAX_DIM)) ? MAX_C : DW'(cols_q);

  always_comb begin
    a_tg  = tg_q;
    a_cnt = cnt_q;
    a_gc  = gc_q;
    if (start_image_i) begin
      a_tg.top    = '0;
      a_tg.left   = '0;
      a_tg.height = rows_c;
      a_tg.width  = cols_c;
      a_tg.single = 1'b1;
      a_gc        = '0;
      if ((rows_c != '0) && (cols_c != '0)) begin
        a_tg.mask = QUAD_N'(1);
        a_cnt     = CNT_W'(1);
      end else begin
        a_tg.mask = '0;
        a_cnt     = '0;
      end
    end
  end

  // ---------------------------------------------------------------- pop
  // Parent halves: upper/left take the ceiling.
  logic [DW:0]       ph_inc, pw_inc;
  logic [DW-1:0]     p_hi, p_lo, p_wl, p_wr;
  logic [CW-1:0]     p_mid_row, p_mid_col;
  logic [QUAD_N-1:0] sel, m_rest;
  group_t            rgn;                  // popped rectangle (mask unused)

  assign ph_inc    = {1'b0, a_tg.height} + {{DW{1'b0}}, 1'b1};
  assign pw_inc    = {1'b0, a_tg.width} + {{DW{1'b0}}, 1'b1};
  assign p_hi      = ph_inc[DW:1];
  assign p_wl      = pw_inc[DW:1];
  assign p_lo      = a_tg.height >> 1;
  assign p_wr      = a_tg.width >> 1;
  assign p_mid_row = CW'(a_tg.top + p_hi);
  assign p_mid_col = CW'(a_tg.left + p_wl);
  assign sel       = a_tg.mask & (~a_tg.mask + QUAD_N'(1));
  assign m_rest    = a_tg.mask & ~sel;

  always_comb begin
    rgn        = a_tg;
    rgn.single = 1'b0;
    rgn.mask   = '0;
    if (!a_tg.single) begin
      priority if (a_tg.mask[QUAD_TL]) begin
        rgn.height = p_hi;
        rgn.width  = p_wl;
      end else if (a_tg.mask[QUAD_TR]) begin
        rgn.left   = p_mid_col;
        rgn.height = p_hi;
        rgn.width  = p_wr;
      end else if (a_tg.mask[QUAD_BL]) begin
        rgn.top    = p_mid_row;
        rgn.height = p_lo;
        rgn.width  = p_wl;
      end else begin
        rgn.top    = p_mid_row;
        rgn.left   = p_mid_col;
        rgn.height = p_lo;
        rgn.width  = p_wr;
      end
    end
  end

  // ---------------------------------------------------------------- split
  // Pushes go BR, BL, TR, TL; once the stack is full the rest are dropped.
  logic [CNT_W-1:0]  c1, free_n;
  logic [QUAD_N-1:0] ne, g_mask;
  logic [2:0]        used;

  assign c1     = a_cnt - CNT_W'(1);
  assign free_n = DEPTH_C - c1;
  assign ne[QUAD_TL] = 1'b1;
  assign ne[QUAD_TR] = (rgn.width >> 1) != '0;
  assign ne[QUAD_BL] = (rgn.height >> 1) != '0;
  assign ne[QUAD_BR] = ne[QUAD_TR] && ne[QUAD_BL];

  always_comb begin
    used   = '0;
    g_mask = '0;
    for (int i = QUAD_N - 1; i >= 0; i--) begin
      if (ne[i] && (CNT_W'(used) < free_n)) begin
        g_mask[i] = 1'b1;
        used      = used + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------- next state
  logic do_pop, emit;

  assign do_pop = acc && (a_cnt != '0) && (sym_leaf || sym_split);
  assign emit   = do_pop && sym_leaf;

  always_comb begin
    tg_d      = tg_q;
    cnt_d     = cnt_q;
    gc_d      = gc_q;
    mem_we    = 1'b0;
    mem_waddr = a_gc;
    mem_wdata = a_tg;
    mem_wdata.mask = m_rest;
    if (acc) begin
      tg_d  = a_tg;
      cnt_d = a_cnt;
      gc_d  = a_gc;
    end
    if (do_pop) begin
      if (sym_split) begin
        cnt_d = c1 + CNT_W'(used);
        // Spill what is left of the top group before the new one takes over.
        if (m_rest != '0) begin
          mem_we = 1'b1;
          gc_d   = a_gc + AW'(1);
        end
        tg_d      = rgn;
        tg_d.mask = g_mask;
      end else begin
        cnt_d = c1;
        if (m_rest != '0) begin
          tg_d.mask = m_rest;
        end else if (a_gc != '0) begin
          tg_d = mtop;
          gc_d = a_gc - AW'(1);
        end else begin
          tg_d.mask = '0;
        end
      end
    end
  end

  // Prefetch the entry that will be on top of memory next cycle.
  assign mem_raddr = gc_d - AW'(1);

  qtbd_stack_mem #(
    .WIDTH (GRP_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------- output stage
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_top_q    <= rgn.top;
      o_left_q   <= rgn.left;
      o_height_q <= rgn.height;
      o_width_q  <= rgn.width;
      o_pixel_q  <= symbol_i[0];
      o_done_q   <= (c1 == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= CFG_DATA_W'(1);
      cols_q      <= CFG_DATA_W'(1);
      tg_q        <= '0;
      gc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tg_q        <= tg_d;
      gc_q        <= gc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_IMAGE_ROWS: rows_q <= cfg_data_i;
          REG_IMAGE_COLS: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fill_top_o    = FILL_POS_W'(o_top_q);
  assign fill_left_o   = FILL_POS_W'(o_left_q);
  assign fill_height_o = FILL_DIM_W'(o_height_q);
  assign fill_width_o  = FILL_DIM_W'(o_width_q);
  assign pixel_value_o = o_pixel_q;
  assign image_done_o  = o_done_q;

endmodule

// ===== rtl/qtbd_checker.sv =====
// Port-level checks for the quadtree bitmap decoder, bound to the top level.
`timescale 1ns / 1ps

module qtbd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [qtbd_pkg::SYMBOL_W-1:0]    symbol_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [qtbd_pkg::FILL_POS_W-1:0]  fill_top_o,
  input logic [qtbd_pkg::FILL_POS_W-1:0]  fill_left_o,
  input logic [qtbd_pkg::FILL_DIM_W-1:0]  fill_height_o,
  input logic [qtbd_pkg::FILL_DIM_W-1:0]  fill_width_o,
  input logic                             pixel_value_o,
  input logic                             image_done_o
);

  import qtbd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A held fill word keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fill_top_o) &&
      $stable(fill_left_o) && $stable(fill_height_o) && $stable(fill_width_o) &&
      $stable(pixel_value_o) && $stable(image_done_o))
    else $error("fill word changed while stalled");

  // Input back-pressure only comes from a blocked output word.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked fill word");

  // A split word never produces a fill.
  a_split_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (symbol_i == SYM_SPLIT) |=> !out_valid_o)
    else $error("fill produced by split word");

  // The unused code is dropped without a fill.
  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (symbol_i != SYM_LEAF0) && (symbol_i != SYM_LEAF1) &&
      (symbol_i != SYM_SPLIT) |=> !out_valid_o)
    else $error("fill produced by unused symbol code");

endmodule

bind quadtree_bitmap_decoder_unit qtbd_checker u_qtbd_checker (.*);

// ===== tb/quadtree_bitmap_decoder_unit_tb.sv =====
// Self-checking testbench for the quadtree bitmap decoder top level.
`timescale 1ns / 1ps

module quadtree_bitmap_decoder_unit_tb;
  import qtbd_pkg::*;

  localparam int MAX_DIM     = 256;
  localparam int STACK_DEPTH = 32;
  // Unused symbol code, ignored by the block.
  localparam logic [SYMBOL_W-1:0] SYM_UNUSED = 2'd3;
  // Index of the two decoder copies: one follows accepted words, one builds stimulus.
  localparam int TRACK_DUT = 0;
  localparam int TRACK_GEN = 1;

  typedef struct packed {
    logic [8:0] top;
    logic [8:0] left;
    logic [8:0] height;
    logic [8:0] width;
  } region_t;

  typedef struct packed {
    logic [FILL_POS_W-1:0] top;
    logic [FILL_POS_W-1:0] left;
    logic [FILL_DIM_W-1:0] height;
    logic [FILL_DIM_W-1:0] width;
    logic                  pixel;
    logic                  done;
  } fill_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic                start;
  } sym_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_IMAGE_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SYMBOL_W-1:0]   symbol_i = SYM_LEAF0;
  logic                  start_image_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [FILL_POS_W-1:0] fill_top_o;
  logic [FILL_POS_W-1:0] fill_left_o;
  logic [FILL_DIM_W-1:0] fill_height_o;
  logic [FILL_DIM_W-1:0] fill_width_o;
  logic                  pixel_value_o;
  logic                  image_done_o;

  quadtree_bitmap_decoder_unit #(
    .MAX_DIM    (MAX_DIM),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .symbol_i     (symbol_i),
    .start_image_i(start_image_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fill_top_o   (fill_top_o),
    .fill_left_o  (fill_left_o),
    .fill_height_o(fill_height_o),
    .fill_width_o (fill_width_o),
    .pixel_value_o(pixel_value_o),
    .image_done_o (image_done_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder shadow: two copies of the rectangle stack. The DUT copy advances on
  // each accepted symbol word, the GEN copy as stimulus is built, so the
  // generator knows which rectangle is on top and can emit well-formed trees.
  // ---------------------------------------------------------------------------
  region_t     dec_stack [2][STACK_DEPTH];
  int unsigned dec_count [2];
  logic [8:0]  img_rows = 9'd1;   // register values as written (reset is 1x1)
  logic [8:0]  img_cols = 9'd1;

  sym_word_t   word_q[$];         // symbol words waiting for the driver
  fill_t       expected_fills[$]; // fills predicted, not yet seen at the output

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int words_taken   = 0;
  int fills_checked = 0;
  int cfg_writes    = 0;
  int stall_burst_left = 0;
  bit stall_burst_done = 1'b0;

  function automatic logic [8:0] clamp_dim(logic [8:0] v);
    return (v > MAX_DIM) ? 9'(MAX_DIM) : v;
  endfunction

  // Empty quadrants are skipped; a push onto a full stack is dropped.
  function automatic void push_region(int c, logic [8:0] t, logic [8:0] l,
                                      logic [8:0] h, logic [8:0] w);
    if (h == 0 || w == 0 || dec_count[c] >= STACK_DEPTH) return;
    dec_stack[c][dec_count[c]] = '{top: t, left: l, height: h, width: w};
    dec_count[c]++;
  endfunction

  // One symbol word through decoder copy c; returns 1 when it yields a fill.
  function automatic bit decode_symbol(int c, logic [SYMBOL_W-1:0] sym, logic start,
                                       output fill_t f);
    region_t    r;
    logic [9:0] hi, lo, wl, wr;
    f = '0;
    if (start) begin
      dec_count[c] = 0;
      push_region(c, 9'd0, 9'd0, clamp_dim(img_rows), clamp_dim(img_cols));
    end
    if (dec_count[c] == 0 || sym > SYM_SPLIT) return 1'b0;
    dec_count[c]--;
    r = dec_stack[c][dec_count[c]];
    if (sym == SYM_SPLIT) begin
      // upper / left halves take the ceiling
      hi = ({1'b0, r.height} + 10'd1) >> 1;
      lo = {1'b0, r.height} >> 1;
      wl = ({1'b0, r.width} + 10'd1) >> 1;
      wr = {1'b0, r.width} >> 1;
      // pushed BR first so TL pops first
      push_region(c, 9'(r.top + hi), 9'(r.left + wl), 9'(lo), 9'(wr));
      push_region(c, 9'(r.top + hi), r.left, 9'(lo), 9'(wl));
      push_region(c, r.top, 9'(r.left + wl), 9'(hi), 9'(wr));
      push_region(c, r.top, r.left, 9'(hi), 9'(wl));
      return 1'b0;
    end
    f.top    = r.top[FILL_POS_W-1:0];
    f.left   = r.left[FILL_POS_W-1:0];
    f.height = r.height;
    f.width  = r.width;
    f.pixel  = sym[0];
    f.done   = (dec_count[c] == 0);
    return 1'b1;
  endfunction

  // Queue a word for the driver and advance the generator's copy.
  task automatic add_word(logic [SYMBOL_W-1:0] sym, logic start);
    fill_t     dummy_fill;
    bit        dummy_hit;
    sym_word_t queued_word;
    queued_word = '{sym: sym, start: start};
    word_q = {word_q, queued_word};
    dummy_hit = decode_symbol(TRACK_GEN, sym, start, dummy_fill);
  endtask

  // Mostly small images, some full size, some empty, some oversized (saturate).
  function automatic logic [8:0] pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return 9'd0;
    if (roll < 8) return 9'($urandom_range(511, MAX_DIM + 1));
    if (roll < 16) return 9'(MAX_DIM);
    if (roll < 80) return 9'($urandom_range(16, 1));
    return 9'($urandom_range(MAX_DIM, 1));
  endfunction

  // One random image: a start word, then symbols chosen against the rectangle
  // on top until the tree closes. A bit of noise: unused codes, stray restarts,
  // splits of single pixels, words after the image is done.
  task automatic gen_image(output int n);
    int                  budget, roll;
    bit                  first;
    logic                st;
    logic [SYMBOL_W-1:0] s;
    region_t             r;
    n = 0;
    first = 1'b1;
    budget = ($urandom_range(9) == 0) ? 150 : $urandom_range(60, 4);
    do begin
      st = first || ($urandom_range(99) < 2);
      if (st) r = '{top: 9'd0, left: 9'd0, height: clamp_dim(img_rows),
                    width: clamp_dim(img_cols)};
      else    r = dec_stack[TRACK_GEN][dec_count[TRACK_GEN] - 1];
      roll = $urandom_range(99);
      if (roll < 4) s = SYM_UNUSED;
      else if (n < budget && (((r.height > 1 || r.width > 1) && roll < 45) || roll >= 97))
        s = SYM_SPLIT;
      else s = $urandom_range(1) ? SYM_LEAF1 : SYM_LEAF0;
      add_word(s, st);
      n++;
      first = 1'b0;
    end while (dec_count[TRACK_GEN] != 0 && n < 400);
    if ($urandom_range(9) == 0) add_word($urandom_range(1) ? SYM_LEAF1 : SYM_SPLIT, 1'b0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_IMAGE_ROWS) img_rows = val;
    else                       img_cols = val;
    cfg_writes++;
  endtask

  // Sender pauses until every fill is back, then lets a split finish inside.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (word_q.size() != 0 || in_valid_i || expected_fills.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic bit field_ok(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v == act_v) return 1'b1;
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one symbol word per handshake. Holds the payload while stalled;
  // the idle decision never looks at in_stall_o.
  // ---------------------------------------------------------------------------
  sym_word_t next_word;
  fill_t     pred_fill;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        words_taken++;
        if (decode_symbol(TRACK_DUT, symbol_i, start_image_i, pred_fill))
          expected_fills = {expected_fills, pred_fill};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          symbol_i      <= next_word.sym;
          start_image_i <= next_word.start;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each fill word against the oldest prediction, and drives
  // out_stall_i. One long stall burst lets the block back up into its input.
  // ---------------------------------------------------------------------------
  fill_t got_fill, exp_fill;
  bit    fill_good;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_fill = '{top: fill_top_o, left: fill_left_o, height: fill_height_o,
                     width: fill_width_o, pixel: pixel_value_o, done: image_done_o};
        if (expected_fills.size() == 0) begin
          $display("%0t: unexpected fill word: expected none, actual %p", $time, got_fill);
          mismatches++;
        end else begin
          exp_fill = expected_fills.pop_front();
          fill_good = 1'b1;
          fill_good &= field_ok("fill_top", exp_fill.top, got_fill.top);
          fill_good &= field_ok("fill_left", exp_fill.left, got_fill.left);
          fill_good &= field_ok("fill_height", exp_fill.height, got_fill.height);
          fill_good &= field_ok("fill_width", exp_fill.width, got_fill.width);
          fill_good &= field_ok("pixel_value", exp_fill.pixel, got_fill.pixel);
          fill_good &= field_ok("image_done", exp_fill.done, got_fill.done);
          if (!fill_good) mismatches++;
        end
        fills_checked++;
        if (fills_checked == 150 && !stall_burst_done) begin
          stall_burst_left = 200;
          stall_burst_done = 1'b1;
        end
      end
      if (stall_burst_left != 0) begin
        out_stall_i <= 1'b1;
        stall_burst_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed phases, then random phases under three idle
  // profiles (sender mostly busy, receiver mostly busy, neither idles).
  // ---------------------------------------------------------------------------
  initial begin
    int n, phase_words;
    dec_count[TRACK_DUT] = 0;
    dec_count[TRACK_GEN] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size 1x1: nothing pending, unused code, split of a single pixel.
    add_word(SYM_LEAF1, 1'b0);
    add_word(SYM_UNUSED, 1'b0);
    add_word(SYM_LEAF1, 1'b1);
    add_word(SYM_SPLIT, 1'b1);
    add_word(SYM_LEAF0, 1'b0);
    add_word(SYM_UNUSED, 1'b1);
    add_word(SYM_LEAF0, 1'b0);
    wait_drained();

    // Oversized rows saturate; walk down the bottom quadrants, restart mid-image.
    write_reg(REG_IMAGE_ROWS, 9'h1FF);
    write_reg(REG_IMAGE_COLS, 9'(MAX_DIM));
    add_word(SYM_SPLIT, 1'b1);
    add_word(SYM_LEAF1, 1'b0);
    add_word(SYM_LEAF0, 1'b0);
    add_word(SYM_SPLIT, 1'b0);
    repeat (3) add_word(SYM_LEAF1, 1'b0);
    add_word(SYM_SPLIT, 1'b0);
    add_word(SYM_LEAF0, 1'b0);
    add_word(SYM_LEAF1, 1'b1);
    wait_drained();

    // Empty image: start pushes nothing.
    write_reg(REG_IMAGE_ROWS, 9'd0);
    write_reg(REG_IMAGE_COLS, 9'd5);
    add_word(SYM_LEAF1, 1'b1);
    add_word(SYM_SPLIT, 1'b1);
    wait_drained();

    // Single column: right quadrants are empty, odd height splits unevenly.
    write_reg(REG_IMAGE_ROWS, 9'd3);
    write_reg(REG_IMAGE_COLS, 9'd1);
    add_word(SYM_SPLIT, 1'b1);
    add_word(SYM_SPLIT, 1'b0);
    add_word(SYM_LEAF1, 1'b0);
    add_word(SYM_LEAF0, 1'b0);
    add_word(SYM_LEAF1, 1'b0);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 8;  recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p == 3) begin
        write_reg(REG_IMAGE_ROWS, 9'(MAX_DIM));
        write_reg(REG_IMAGE_COLS, 9'(MAX_DIM));
      end else if (p == 6) begin
        write_reg(REG_IMAGE_ROWS, 9'd1);
        write_reg(REG_IMAGE_COLS, 9'd1);
      end else begin
        write_reg(REG_IMAGE_ROWS, pick_dim());
        write_reg(REG_IMAGE_COLS, pick_dim());
      end
      phase_words = 0;
      while (phase_words < 80) begin
        gen_image(n);
        phase_words += n;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Run covered %0d symbol words and %0d fill words over %0d register writes,",
             words_taken, fills_checked, cfg_writes);
    $display("with empty, saturated and full-size images and three idle profiles.");
    if (mismatches == 0) begin
      $display("PASS quadtree_bitmap_decoder_unit");
    end else begin
      $display("FAIL quadtree_bitmap_decoder_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL quadtree_bitmap_decoder_unit");
    $finish;
  end

endmodule
